### src/lgsc_pkg.sv
// lgsc_pkg: shared constants, types and operation codes for the glyph slot cache
// used by lgsc_store, lgsc_scan and lru_glyph_slot_cache; no dependencies
`timescale 1ns / 1ps

package lgsc_pkg;

	localparam int SLOTS      = 16;
	localparam int STAMP_BITS = 32;
	localparam int IDX_W      = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int KEY_W      = 16;
	localparam int SIZE_W     = 8;
	localparam int OP_W       = 2;
	localparam int OUT_IDX_W  = 4;

	typedef logic [IDX_W-1:0]      idx_t;
	typedef logic [STAMP_BITS-1:0] stamp_t;
	typedef logic [KEY_W-1:0]      key_t;
	typedef logic [SIZE_W-1:0]     size_t;
	typedef logic [OP_W-1:0]       op_t;

	localparam op_t OP_GET      = 2'd0;
	localparam op_t OP_PRECACHE = 2'd1;
	localparam op_t OP_UNCACHE  = 2'd2;
	localparam op_t OP_QUERY    = 2'd3;

	localparam stamp_t STAMP_MAX  = '1;
	localparam stamp_t STAMP_INIT = STAMP_BITS'(1);
	localparam idx_t   LAST_IDX   = IDX_W'(SLOTS - 1);

	typedef struct packed {
		stamp_t stamp;
		key_t   key;
		size_t  width;
		size_t  height;
	} entry_t;

	typedef struct packed {
		logic   stamp_we;
		logic   fill_we;
		idx_t   addr;
		stamp_t stamp;
		key_t   key;
		size_t  width;
		size_t  height;
	} wr_t;

	typedef struct packed {
		logic hit;
		idx_t hit_idx;
		idx_t vic_idx;
	} scan_t;

endpackage

### src/lru_glyph_slot_cache.sv
// lru_glyph_slot_cache: fully associative lru cache of character codes with glyph sizes
// depends on lgsc_pkg, lgsc_store and lgsc_scan
`timescale 1ns / 1ps

// A transaction goes through a scan and an update before its result is loaded: the
// compare unit visits one slot per cycle looking for the key and the least recently
// used victim, then the update is applied once the output register can take the result.
// in_stall stays high from acceptance until the update is done, so a new transaction is
// not accepted before the last one is through; the result sits in an output register, so
// the next transaction is accepted while it waits to be taken.

module lru_glyph_slot_cache (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [1:0] operation,
	input  logic [15:0] char_code,
	input  logic       fill_ok,
	input  logic [7:0] fill_width,
	input  logic [7:0] fill_height,
	output logic       out_valid,
	input  logic       out_stall,
	output logic       success,
	output logic       was_hit,
	output logic [3:0] slot_index,
	output logic       evicted_valid,
	output logic [15:0] evicted_char,
	output logic [7:0] char_width,
	output logic [7:0] char_height
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_SCAN = 2'd1;
	localparam logic [1:0] ST_UPD  = 2'd2;

	logic [1:0] state_q;
	lgsc_pkg::idx_t   cnt_q;
	lgsc_pkg::stamp_t counter_q;

	lgsc_pkg::op_t   op_q;
	lgsc_pkg::key_t  key_q;
	logic            fill_ok_q;
	lgsc_pkg::size_t fill_w_q;
	lgsc_pkg::size_t fill_h_q;

	logic            out_valid_q;
	logic            success_q;
	logic            was_hit_q;
	logic [3:0]      slot_index_q;
	logic            evicted_valid_q;
	lgsc_pkg::key_t  evicted_char_q;
	lgsc_pkg::size_t char_width_q;
	lgsc_pkg::size_t char_height_q;

	lgsc_pkg::idx_t   rd_addr;
	lgsc_pkg::entry_t ent;
	lgsc_pkg::wr_t    wr;
	lgsc_pkg::scan_t  scan;
	lgsc_pkg::idx_t   sel_idx;

	logic in_fire;
	logic upd_fire;
	logic bump;

	logic            n_success;
	logic            n_hit;
	lgsc_pkg::idx_t  n_slot;
	logic            n_ev_valid;
	lgsc_pkg::key_t  n_ev_char;
	lgsc_pkg::size_t n_cw;
	lgsc_pkg::size_t n_ch;

	assign in_stall = (state_q != ST_IDLE);
	assign in_fire  = in_valid && !in_stall;
	assign upd_fire = (state_q == ST_UPD) && (!out_valid_q || !out_stall);
	assign sel_idx  = scan.hit ? scan.hit_idx : scan.vic_idx;
	assign rd_addr  = (state_q == ST_SCAN) ? cnt_q : sel_idx;

	lgsc_store u_store (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_addr (rd_addr),
		.rd_data (ent),
		.wr      (wr)
	);

	lgsc_scan u_scan (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (state_q == ST_SCAN),
		.first  (cnt_q == '0),
		.idx    (cnt_q),
		.key    (key_q),
		.ent    (ent),
		.res    (scan)
	);

	// update decision for the selected slot
	always_comb begin
		n_success  = 1'b0;
		n_hit      = 1'b0;
		n_slot     = '0;
		n_ev_valid = 1'b0;
		n_ev_char  = '0;
		n_cw       = '0;
		n_ch       = '0;
		bump       = 1'b0;
		wr.stamp_we = 1'b0;
		wr.fill_we  = 1'b0;
		wr.addr     = sel_idx;
		wr.stamp    = counter_q;
		wr.key      = key_q;
		wr.width    = fill_w_q;
		wr.height   = fill_h_q;
		if (scan.hit) begin
			n_success = 1'b1;
			n_hit     = 1'b1;
			n_slot    = sel_idx;
			case (op_q)
				lgsc_pkg::OP_GET: begin
					wr.stamp_we = 1'b1;
					bump        = 1'b1;
					n_cw        = ent.width;
					n_ch        = ent.height;
				end
				lgsc_pkg::OP_PRECACHE: begin
					wr.stamp_we = 1'b1;
				end
				lgsc_pkg::OP_UNCACHE: begin
					wr.stamp_we = 1'b1;
					wr.stamp    = '0;
				end
				default: begin
				end
			endcase
		end else if (op_q == lgsc_pkg::OP_GET || op_q == lgsc_pkg::OP_PRECACHE) begin
			n_slot      = sel_idx;
			wr.stamp_we = 1'b1;
			wr.stamp    = '0;
			if (ent.stamp != '0) begin
				n_ev_valid = 1'b1;
				n_ev_char  = ent.key;
			end
			if (fill_ok_q) begin
				wr.fill_we = 1'b1;
				wr.stamp   = counter_q;
				n_success  = 1'b1;
				if (op_q == lgsc_pkg::OP_GET) begin
					bump = 1'b1;
					n_cw = fill_w_q;
					n_ch = fill_h_q;
				end
			end
		end
		wr.stamp_we = wr.stamp_we && upd_fire;
		wr.fill_we  = wr.fill_we && upd_fire;
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			cnt_q     <= '0;
			counter_q <= lgsc_pkg::STAMP_INIT;
		end else begin
			case (state_q)
				ST_IDLE: begin
					cnt_q <= '0;
					if (in_fire) begin
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (cnt_q == lgsc_pkg::LAST_IDX) begin
						state_q <= ST_UPD;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				ST_UPD: begin
					if (upd_fire) begin
						state_q <= ST_IDLE;
						if (bump && counter_q != lgsc_pkg::STAMP_MAX) begin
							counter_q <= counter_q + 1'b1;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			op_q      <= operation;
			key_q     <= char_code;
			fill_ok_q <= fill_ok;
			fill_w_q  <= fill_width;
			fill_h_q  <= fill_height;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (upd_fire) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (upd_fire) begin
			success_q       <= n_success;
			was_hit_q       <= n_hit;
			slot_index_q    <= lgsc_pkg::OUT_IDX_W'(n_slot);
			evicted_valid_q <= n_ev_valid;
			evicted_char_q  <= n_ev_char;
			char_width_q    <= n_cw;
			char_height_q   <= n_ch;
		end
	end

	assign out_valid     = out_valid_q;
	assign success       = success_q;
	assign was_hit       = was_hit_q;
	assign slot_index    = slot_index_q;
	assign evicted_valid = evicted_valid_q;
	assign evicted_char  = evicted_char_q;
	assign char_width    = char_width_q;
	assign char_height   = char_height_q;

endmodule

### src/lgsc_store.sv
// lgsc_store: slot storage (stamp, key, glyph size) with one read and one write port
// depends on lgsc_pkg; stamps clear on reset, key and sizes are written on fill only
`timescale 1ns / 1ps

module lgsc_store (
	input  logic            clk,
	input  logic            arst_n,
	input  lgsc_pkg::idx_t  rd_addr,
	output lgsc_pkg::entry_t rd_data,
	input  lgsc_pkg::wr_t   wr
);

	lgsc_pkg::stamp_t stamp_q  [lgsc_pkg::SLOTS];
	lgsc_pkg::key_t   key_q    [lgsc_pkg::SLOTS];
	lgsc_pkg::size_t  width_q  [lgsc_pkg::SLOTS];
	lgsc_pkg::size_t  height_q [lgsc_pkg::SLOTS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < lgsc_pkg::SLOTS; i++) begin
				stamp_q[i] <= '0;
			end
		end else if (wr.stamp_we) begin
			stamp_q[wr.addr] <= wr.stamp;
		end
	end

	always_ff @(posedge clk) begin
		if (wr.fill_we) begin
			key_q[wr.addr]    <= wr.key;
			width_q[wr.addr]  <= wr.width;
			height_q[wr.addr] <= wr.height;
		end
	end

	always_comb begin
		rd_data.stamp  = stamp_q[rd_addr];
		rd_data.key    = key_q[rd_addr];
		rd_data.width  = width_q[rd_addr];
		rd_data.height = height_q[rd_addr];
	end

endmodule

### src/lgsc_scan.sv
// lgsc_scan: shared compare unit, one slot per cycle, for key match and lru victim
// depends on lgsc_pkg; driven by the sequencer in lru_glyph_slot_cache
`timescale 1ns / 1ps

module lgsc_scan (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             step,
	input  logic             first,
	input  lgsc_pkg::idx_t   idx,
	input  lgsc_pkg::key_t   key,
	input  lgsc_pkg::entry_t ent,
	output lgsc_pkg::scan_t  res
);

	logic             hit_q;
	logic             empty_q;
	lgsc_pkg::idx_t   hit_idx_q;
	lgsc_pkg::idx_t   vic_q;
	lgsc_pkg::stamp_t min_q;

	logic occupied;
	logic match;
	logic less;

	always_comb begin
		occupied = (ent.stamp != '0);
		match    = occupied && (ent.key == key);
		less     = (ent.stamp < min_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_q   <= 1'b0;
			empty_q <= 1'b0;
		end else if (step) begin
			if (first) begin
				hit_q   <= match;
				empty_q <= !occupied;
			end else begin
				if (match && !hit_q) begin
					hit_q <= 1'b1;
				end
				if (!empty_q && !occupied) begin
					empty_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			if (first) begin
				hit_idx_q <= idx;
				vic_q     <= idx;
				min_q     <= ent.stamp;
			end else begin
				if (match && !hit_q) begin
					hit_idx_q <= idx;
				end
				if (!empty_q) begin
					if (!occupied) begin
						vic_q <= idx;
					end else if (less) begin
						vic_q <= idx;
						min_q <= ent.stamp;
					end
				end
			end
		end
	end

	assign res.hit     = hit_q;
	assign res.hit_idx = hit_idx_q;
	assign res.vic_idx = vic_q;

endmodule
